// File: design/ugpb_pkg.sv
// shared constants for the uniform grid point binning block
package ugpb_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;

  localparam int IDX_W     = 6;
  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 12;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TAG_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

endpackage

// File: design/ugpb_div.sv
// restoring divider, one quotient bit per cycle
module ugpb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ugpb_pkg::COORD_W-1:0]  dividend,
  input  logic [ugpb_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [ugpb_pkg::COORD_W-1:0]  quotient
);

  localparam int CW = $clog2(ugpb_pkg::COORD_W + 1);

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [ugpb_pkg::SIZE_W-1:0]  rem;
  logic [ugpb_pkg::SIZE_W:0]    sh;
  logic [ugpb_pkg::SIZE_W:0]    diff;
  logic                         ge;

  assign sh   = {rem, quotient[ugpb_pkg::COORD_W-1]};
  assign ge   = sh >= {1'b0, divisor};
  assign diff = sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ugpb_pkg::COORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[ugpb_pkg::SIZE_W-1:0] : sh[ugpb_pkg::SIZE_W-1:0];
      quotient <= {quotient[ugpb_pkg::COORD_W-2:0], ge};
    end
  end

endmodule

// File: design/ugpb_ram.sv
// single write port, single read port memory with registered read
module ugpb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/uniform_grid_point_binning_top.sv
// top level of the uniform grid point binning block
// insert: divides both coordinates by the cell size, then reads and updates the cell and point memories, no output word
// query: two corner divisions, then a visit to each cell in the box and to each point found
// one item in flight at a time; results leave through an output register
// reset runs a clearing pass over the cell and point memories with in_ready low
// the same pass runs again on every fifteenth batch start when the cell tags wrap
module uniform_grid_point_binning_top #(
  parameter int MAX_POINTS  = ugpb_pkg::MAX_POINTS_DEF,
  parameter int MAX_COLUMNS = ugpb_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ugpb_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ugpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ugpb_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic                            batch_start,
  input  logic [ugpb_pkg::IDX_W-1:0]      item_index,
  input  logic                            item_active,
  input  logic signed [15:0]              pos_x,
  input  logic signed [15:0]              pos_y,
  input  logic signed [15:0]              far_x,
  input  logic signed [15:0]              far_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ugpb_pkg::IDX_W-1:0]      found_index,
  output logic                            found_valid,
  output logic                            last
);

  localparam int NUM_CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int CAW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int PW    = $clog2(MAX_POINTS);
  localparam int XW    = $clog2(MAX_COLUMNS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);
  localparam int TW    = ugpb_pkg::TAG_W;
  localparam int CDW   = TW + 2 * PW;
  localparam int PDW   = TW + PW;
  localparam int SWEEP = (NUM_CELLS > MAX_POINTS) ? NUM_CELLS : MAX_POINTS;
  localparam int SWW   = $clog2(SWEEP + 1);
  localparam int CW    = ugpb_pkg::COORD_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_QCELL = 4'd7;
  localparam logic [3:0] S_QCHK  = 4'd8;
  localparam logic [3:0] S_QEMIT = 4'd9;
  localparam logic [3:0] S_QNEXT = 4'd10;
  localparam logic [3:0] S_QEND  = 4'd11;

  logic signed [15:0]           origin_x;
  logic signed [15:0]           origin_y;
  logic [ugpb_pkg::SIZE_W-1:0]  cell_size;
  logic [ugpb_pkg::COUNT_W-1:0] columns;
  logic [ugpb_pkg::COUNT_W-1:0] rows;

  logic [3:0]                   state;
  logic [SWW-1:0]               scnt;
  logic                         resume;
  logic                         phase;
  logic [TW-1:0]                epoch;

  logic                         func_r;
  logic [ugpb_pkg::IDX_W-1:0]   idx_r;
  logic signed [15:0]           pos_x_r;
  logic signed [15:0]           pos_y_r;
  logic signed [15:0]           far_x_r;
  logic signed [15:0]           far_y_r;

  logic [XW-1:0]                x;
  logic [XW-1:0]                x0;
  logic [XW-1:0]                x1;
  logic [YW-1:0]                y;
  logic [YW-1:0]                y0;
  logic [YW-1:0]                y1;
  logic [PW-1:0]                p;
  logic [PW-1:0]                ct;
  logic [PW-1:0]                pend;
  logic                         pend_v;

  logic [XW-1:0]                cols_eff;
  logic [YW-1:0]                rows_eff;
  logic [ugpb_pkg::SIZE_W-1:0]  size_eff;
  logic signed [16:0]           offx;
  logic signed [16:0]           offy;
  logic [CW-1:0]                dvx;
  logic [CW-1:0]                dvy;
  logic [CW-1:0]                qx;
  logic [CW-1:0]                qy;
  logic                         dx_done;
  logic                         dy_done;
  logic                         div_start;
  logic [XW-1:0]                cx;
  logic [YW-1:0]                cy;
  logic [XW+YW-1:0]             prod;
  logic [CAW-1:0]               cad;
  logic [PW-1:0]                pidx;

  logic                         cwe;
  logic [CAW-1:0]               cwaddr;
  logic [CDW-1:0]               cwdata;
  logic                         cre;
  logic [CDW-1:0]               crdata;
  logic                         pwe;
  logic [PW-1:0]                pwaddr;
  logic [PDW-1:0]               pwdata;
  logic                         pre;
  logic [PW-1:0]                praddr;
  logic [PDW-1:0]               prdata;

  logic [TW-1:0]                ctag;
  logic [PW-1:0]                chead;
  logic [PW-1:0]                ctail;
  logic [TW-1:0]                ptag;
  logic [PW-1:0]                pnext;
  logic                         c_hit;

  logic                         out_free;
  logic                         load;
  logic [PW-1:0]                ld_idx;
  logic                         ld_valid;
  logic                         ld_last;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // effective configuration
  always_comb begin
    if (columns == '0) begin
      cols_eff = XW'(1);
    end else if (32'(columns) > MAX_COLUMNS) begin
      cols_eff = XW'(MAX_COLUMNS);
    end else begin
      cols_eff = XW'(columns);
    end
    if (rows == '0) begin
      rows_eff = YW'(1);
    end else if (32'(rows) > MAX_ROWS) begin
      rows_eff = YW'(MAX_ROWS);
    end else begin
      rows_eff = YW'(rows);
    end
    size_eff = (cell_size == '0) ? ugpb_pkg::SIZE_W'(1) : cell_size;
  end

  // offsets, negatives clamp to zero
  always_comb begin
    offx = phase ? ({far_x_r[15], far_x_r} - {origin_x[15], origin_x})
                 : ({pos_x_r[15], pos_x_r} - {origin_x[15], origin_x});
    offy = phase ? ({far_y_r[15], far_y_r} - {origin_y[15], origin_y})
                 : ({pos_y_r[15], pos_y_r} - {origin_y[15], origin_y});
    dvx  = offx[16] ? '0 : offx[CW-1:0];
    dvy  = offy[16] ? '0 : offy[CW-1:0];
  end

  assign div_start = (state == S_START);

  ugpb_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvx),
    .divisor  (size_eff),
    .done     (dx_done),
    .quotient (qx)
  );

  ugpb_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvy),
    .divisor  (size_eff),
    .done     (dy_done),
    .quotient (qy)
  );

  // clamp to last column and row
  always_comb begin
    cx = (qx > CW'(cols_eff - 1'b1)) ? (cols_eff - 1'b1) : XW'(qx);
    cy = (qy > CW'(rows_eff - 1'b1)) ? (rows_eff - 1'b1) : YW'(qy);
  end

  assign prod   = (XW+YW)'(y) * (XW+YW)'(cols_eff) + (XW+YW)'(x);
  assign cad    = CAW'(prod);
  assign pidx   = PW'(idx_r);

  assign ctag  = crdata[CDW-1 -: TW];
  assign chead = crdata[2*PW-1:PW];
  assign ctail = crdata[PW-1:0];
  assign ptag  = prdata[PDW-1 -: TW];
  assign pnext = prdata[PW-1:0];
  assign c_hit = (ctag == epoch);

  ugpb_ram #(.DEPTH(NUM_CELLS), .AW(CAW), .DW(CDW)) u_cell_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (cwdata),
    .re    (cre),
    .raddr (cad),
    .rdata (crdata)
  );

  ugpb_ram #(.DEPTH(MAX_POINTS), .AW(PW), .DW(PDW)) u_point_ram (
    .clk   (clk),
    .we    (pwe),
    .waddr (pwaddr),
    .wdata (pwdata),
    .re    (pre),
    .raddr (praddr),
    .rdata (prdata)
  );

  // memory port control and output load
  always_comb begin
    cwe      = 1'b0;
    cwaddr   = cad;
    cwdata   = {epoch, (c_hit ? chead : pidx), pidx};
    cre      = 1'b0;
    pwe      = 1'b0;
    pwaddr   = pidx;
    pwdata   = {epoch, pidx};
    pre      = 1'b0;
    praddr   = pidx;
    load     = 1'b0;
    ld_idx   = pend;
    ld_valid = 1'b1;
    ld_last  = 1'b0;
    case (state)
      S_CLEAR: begin
        cwe    = 32'(scnt) < NUM_CELLS;
        cwaddr = CAW'(scnt);
        cwdata = '0;
        pwe    = 32'(scnt) < MAX_POINTS;
        pwaddr = PW'(scnt);
        pwdata = '0;
      end
      S_ADDR: begin
        cre = 1'b1;
        pre = 1'b1;
      end
      S_UPD: begin
        cwe = (ptag != epoch);
        pwe = (ptag != epoch);
      end
      S_LINK: begin
        pwe    = 1'b1;
        pwaddr = ct;
      end
      S_QCELL: begin
        cre = 1'b1;
      end
      S_QEMIT: begin
        load   = pend_v && out_free;
        pre    = (p != ct);
        praddr = p;
      end
      S_QEND: begin
        load     = out_free;
        ld_idx   = pend_v ? pend : '0;
        ld_valid = pend_v;
        ld_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      cell_size <= ugpb_pkg::SIZE_W'(32);
      columns   <= ugpb_pkg::COUNT_W'(16);
      rows      <= ugpb_pkg::COUNT_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        ugpb_pkg::REG_ORIGIN_X:  origin_x  <= cfg_data;
        ugpb_pkg::REG_ORIGIN_Y:  origin_y  <= cfg_data;
        ugpb_pkg::REG_CELL_SIZE: cell_size <= cfg_data[ugpb_pkg::SIZE_W-1:0];
        ugpb_pkg::REG_COLUMNS:   columns   <= cfg_data[ugpb_pkg::COUNT_W-1:0];
        ugpb_pkg::REG_ROWS:      rows      <= cfg_data[ugpb_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scnt      <= '0;
      resume    <= 1'b0;
      phase     <= 1'b0;
      epoch     <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          scnt <= scnt + 1'b1;
          if (scnt == SWW'(SWEEP - 1)) begin
            epoch <= TW'(1);
            state <= resume ? S_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            phase <= 1'b0;
            if (func == ugpb_pkg::FUNC_QUERY) begin
              state <= S_START;
            end else begin
              resume <= item_active && (32'(item_index) < MAX_POINTS);
              if (batch_start && (epoch == '1)) begin
                scnt  <= '0;
                state <= S_CLEAR;
              end else begin
                if (batch_start) begin
                  epoch <= epoch + 1'b1;
                end
                state <= (item_active && (32'(item_index) < MAX_POINTS)) ? S_START : S_IDLE;
              end
            end
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dx_done && dy_done) begin
            if (func_r == ugpb_pkg::FUNC_INSERT) begin
              x     <= cx;
              y     <= cy;
              state <= S_ADDR;
            end else if (!phase) begin
              x0    <= cx;
              y0    <= cy;
              phase <= 1'b1;
              state <= S_START;
            end else begin
              x1 <= cx;
              y1 <= cy;
              x  <= x0;
              y  <= y0;
              state <= ((x0 > cx) || (y0 > cy)) ? S_QEND : S_QCELL;
            end
          end
        end
        S_ADDR: begin
          state <= S_UPD;
        end
        S_UPD: begin
          ct    <= ctail;
          state <= ((ptag != epoch) && c_hit) ? S_LINK : S_IDLE;
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        S_QCELL: begin
          state <= S_QCHK;
        end
        S_QCHK: begin
          if (c_hit) begin
            p     <= chead;
            ct    <= ctail;
            state <= S_QEMIT;
          end else if (x != x1) begin
            x     <= x + 1'b1;
            state <= S_QCELL;
          end else if (y != y1) begin
            x     <= x0;
            y     <= y + 1'b1;
            state <= S_QCELL;
          end else begin
            state <= S_QEND;
          end
        end
        S_QEMIT: begin
          if (!pend_v || out_free) begin
            pend   <= p;
            pend_v <= 1'b1;
            if (p != ct) begin
              state <= S_QNEXT;
            end else if (x != x1) begin
              x     <= x + 1'b1;
              state <= S_QCELL;
            end else if (y != y1) begin
              x     <= x0;
              y     <= y + 1'b1;
              state <= S_QCELL;
            end else begin
              state <= S_QEND;
            end
          end
        end
        S_QNEXT: begin
          p     <= pnext;
          state <= S_QEMIT;
        end
        S_QEND: begin
          if (out_free) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input word capture and output word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r  <= func;
      idx_r   <= item_index;
      pos_x_r <= pos_x;
      pos_y_r <= pos_y;
      far_x_r <= far_x;
      far_y_r <= far_y;
    end
    if (load) begin
      found_index <= ugpb_pkg::IDX_W'(ld_idx);
      found_valid <= ld_valid;
      last        <= ld_last;
    end
  end

endmodule

// File: design/ugpb_checker.sv
// port-level checks for the uniform grid point binning block
module ugpb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ugpb_pkg::IDX_W-1:0]     found_index,
  input logic                           found_valid,
  input logic                           last
);

  // held word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found_index) && $stable(last))
    else $error("output word changed while stalled");

  // empty answer is always the closing word
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found_valid |-> last && (found_index == '0))
    else $error("empty answer without last");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // a query word may only appear when no input can be taken between its parts
  a_no_idle_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last && out_ready |-> !in_ready)
    else $error("block idle while query words remain");

endmodule

bind uniform_grid_point_binning_top ugpb_checker u_ugpb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found_index (found_index),
  .found_valid (found_valid),
  .last        (last)
);

// File: test/uniform_grid_point_binning_top_test.sv
// self-checking testbench for the uniform grid point binning top level
module uniform_grid_point_binning_top_test;

  localparam int NPTS  = ugpb_pkg::MAX_POINTS_DEF;
  localparam int NCOLS = ugpb_pkg::MAX_COLUMNS_DEF;
  localparam int NROWS = ugpb_pkg::MAX_ROWS_DEF;
  localparam int NCELL = NCOLS * NROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int IW  = ugpb_pkg::IDX_W;
  localparam int RIW = ugpb_pkg::CFG_IDX_W;
  localparam int DW  = ugpb_pkg::CFG_W;
  localparam logic F_INS = ugpb_pkg::FUNC_INSERT;
  localparam logic F_QRY = ugpb_pkg::FUNC_QUERY;

  typedef struct {
    logic              fn;
    logic              bstart;
    logic [IW-1:0]     idx;
    logic              active;
    logic signed [15:0] px, py, fx, fy;
  } item_t;

  typedef struct {
    logic [IW-1:0]    idx;
    logic             valid;
    logic             lst;
  } hit_t;

  typedef struct {
    item_t it;
    bit    typed;
    hit_t  hit;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [RIW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0, batch_start = 1'b0, item_active = 1'b0;
  logic [IW-1:0] item_index = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0, far_x = '0, far_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IW-1:0] found_index;
  logic found_valid, last;

  uniform_grid_point_binning_top u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .batch_start, .item_index, .item_active,
    .pos_x, .pos_y, .far_x, .far_y,
    .out_valid, .out_ready, .found_index, .found_valid, .last
  );

  always #1 clk = ~clk;

  // grid model state
  int g_org_x, g_org_y, g_size, g_cols, g_rows;
  bit g_nonempty[NCELL];
  int g_head[NCELL], g_tail[NCELL];
  int g_next[NPTS];
  bit g_binned[NPTS];

  hit_t pending_hits[$];
  int send_pct, recv_pct;
  int mismatches, items_sent, words_seen, queries_sent, idle_cycles;

  function automatic int eff_cols();
    return (g_cols == 0) ? 1 : (g_cols > NCOLS ? NCOLS : g_cols);
  endfunction

  function automatic int eff_rows();
    return (g_rows == 0) ? 1 : (g_rows > NROWS ? NROWS : g_rows);
  endfunction

  function automatic int bin_of(int pos, int org, int count);
    int off, q;
    off = pos - org;
    if (off < 0) return 0;
    q = off / ((g_size == 0) ? 1 : g_size);
    return (q > count - 1) ? count - 1 : q;
  endfunction

  function automatic void clear_grid();
    foreach (g_nonempty[i]) g_nonempty[i] = 1'b0;
    foreach (g_binned[i]) g_binned[i] = 1'b0;
  endfunction

  function automatic void apply_reg(logic [RIW-1:0] r, logic [DW-1:0] d);
    case (r)
      ugpb_pkg::REG_ORIGIN_X:  g_org_x = $signed(d);
      ugpb_pkg::REG_ORIGIN_Y:  g_org_y = $signed(d);
      ugpb_pkg::REG_CELL_SIZE: g_size = d[ugpb_pkg::SIZE_W-1:0];
      ugpb_pkg::REG_COLUMNS:   g_cols = d[ugpb_pkg::COUNT_W-1:0];
      ugpb_pkg::REG_ROWS:      g_rows = d[ugpb_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  // bins an insert or lists the points found by a query
  function automatic void bin_or_lookup(item_t it, output hit_t hits[$]);
    int cols, rws, cx, cy, c, x0, y0, x1, y1, p, steps;
    hit_t h;
    hits = {};
    cols = eff_cols();
    rws = eff_rows();
    if (it.fn == F_INS) begin
      if (it.bstart) clear_grid();
      if (!it.active || g_binned[it.idx]) return;
      cx = bin_of(it.px, g_org_x, cols);
      cy = bin_of(it.py, g_org_y, rws);
      c = cy * cols + cx;
      if (g_nonempty[c]) g_next[g_tail[c]] = it.idx;
      else begin
        g_head[c] = it.idx;
        g_nonempty[c] = 1'b1;
      end
      g_tail[c] = it.idx;
      g_binned[it.idx] = 1'b1;
      return;
    end
    x0 = bin_of(it.px, g_org_x, cols);
    y0 = bin_of(it.py, g_org_y, rws);
    x1 = bin_of(it.fx, g_org_x, cols);
    y1 = bin_of(it.fy, g_org_y, rws);
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        c = y * cols + x;
        if (!g_nonempty[c]) continue;
        p = g_head[c];
        steps = 0;
        while (hits.size() < NPTS && steps < NPTS) begin
          h.idx = p;
          h.valid = 1'b1;
          h.lst = 1'b0;
          hits = {hits, h};
          steps++;
          if (p == g_tail[c]) break;
          p = g_next[p];
        end
      end
    end
    if (hits.size() == 0) begin
      h.idx = '0;
      h.valid = 1'b0;
      h.lst = 1'b1;
      hits = {hits, h};
    end else hits[hits.size()-1].lst = 1'b1;
  endfunction

  task automatic send_word(item_t it, bit typed, hit_t typed_hit);
    hit_t hits[$];
    @(negedge clk);
    func = it.fn;
    batch_start = it.bstart;
    item_index = it.idx;
    item_active = it.active;
    pos_x = it.px;
    pos_y = it.py;
    far_x = it.fx;
    far_y = it.fy;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    bin_or_lookup(it, hits);
    if (typed) hits = '{typed_hit};
    pending_hits = {pending_hits, hits};
    items_sent++;
    if (it.fn == F_QRY) queries_sent++;
    if ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    // an insert leaves no word behind, and a batch start may trigger a clearing pass
    repeat (64) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [RIW-1:0] r, logic [DW-1:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = d;
    apply_reg(r, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic signed [15:0] near_grid(int org, int count);
    int sz, v;
    sz = (g_size == 0) ? 1 : g_size;
    if ($urandom_range(9) == 0) return $urandom;
    v = org - sz + $urandom_range(0, (count + 2) * sz);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic item_t random_word(bit first);
    item_t it;
    int cols, rws;
    cols = eff_cols();
    rws = eff_rows();
    it.fn = first ? F_INS : ($urandom_range(99) < 30 ? F_QRY : F_INS);
    it.bstart = first ? 1'b1 : ($urandom_range(99) < 4);
    it.idx = $urandom;
    it.active = ($urandom_range(99) < 85);
    it.px = near_grid(g_org_x, cols);
    it.py = near_grid(g_org_y, rws);
    it.fx = near_grid(g_org_x, cols);
    it.fy = near_grid(g_org_y, rws);
    return it;
  endfunction

  // output side
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: index %0d valid %0b last %0b",
                   found_index, found_valid, last);
      end else begin
        if (found_index !== pending_hits[0].idx || found_valid !== pending_hits[0].valid ||
            last !== pending_hits[0].lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected index %0d valid %0b last %0b, got %0d %0b %0b",
                     pending_hits[0].idx, pending_hits[0].valid, pending_hits[0].lst,
                     found_index, found_valid, last);
        end
        void'(pending_hits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout with %0d words outstanding", pending_hits.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk(logic fn, logic bs, int idx, logic act, int px, int py,
                              int fx, int fy, bit typed, int hidx, logic hv, logic hl);
    row_t r;
    r.it.fn = fn;
    r.it.bstart = bs;
    r.it.idx = idx;
    r.it.active = act;
    r.it.px = px;
    r.it.py = py;
    r.it.fx = fx;
    r.it.fy = fy;
    r.typed = typed;
    r.hit.idx = hidx;
    r.hit.valid = hv;
    r.hit.lst = hl;
    return r;
  endfunction

  initial begin
    item_t it;
    hit_t none;
    int cfg_set;
    none = '{idx: '0, valid: 1'b0, lst: 1'b0};
    g_org_x = 0;
    g_org_y = 0;
    g_size = 32;
    g_cols = 16;
    g_rows = 16;
    clear_grid();
    send_pct = 0;
    recv_pct = 0;
    mismatches = 0;
    items_sent = 0;
    words_seen = 0;
    queries_sent = 0;
    idle_cycles = 0;

    // empty after reset, corner clamps, inactive and repeated points, inverted box
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, -32768, -32768, 32767, 32767, 1, 0, 0, 1)};
    dir_rows = {dir_rows, mk(F_INS, 1, 0, 1, -32768, -32768, 32767, 32767, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_INS, 0, 63, 1, 32767, 32767, -32768, -32768, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_INS, 0, 5, 0, 40, 40, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_INS, 0, 0, 1, 300, 300, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_INS, 0, 7, 1, 10, 31, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_INS, 0, 42, 1, 32, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, -32768, -32768, 32767, 32767, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, 32767, 32767, 32767, 32767, 1, 63, 1, 1)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, 100, 100, 0, 0, 1, 0, 0, 1)};
    dir_rows = {dir_rows, mk(F_INS, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, -32768, -32768, 32767, 32767, 1, 0, 0, 1)};
    dir_rows = {dir_rows, mk(F_INS, 0, 9, 1, 511, 511, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(F_QRY, 0, 0, 0, 480, 480, 600, 600, 0, 0, 0, 0)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].hit);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      send_pct = (ph < 2) ? 25 : (ph < 4 ? 88 : 0);
      recv_pct = (ph < 2) ? 88 : (ph < 4 ? 25 : 0);
      cfg_set = ph;
      case (cfg_set)
        0: begin
          write_reg(ugpb_pkg::REG_ORIGIN_X, 16'h8000);
          write_reg(ugpb_pkg::REG_ORIGIN_Y, 16'h7fff);
          write_reg(ugpb_pkg::REG_CELL_SIZE, 16'd4095);
        end
        1: begin
          write_reg(ugpb_pkg::REG_ORIGIN_X, 16'hff00);
          write_reg(ugpb_pkg::REG_ORIGIN_Y, 16'h0040);
          write_reg(ugpb_pkg::REG_CELL_SIZE, 16'd0);
          write_reg(ugpb_pkg::REG_COLUMNS, 16'd0);
          write_reg(ugpb_pkg::REG_ROWS, 16'd31);
        end
        2: begin
          write_reg(ugpb_pkg::REG_CELL_SIZE, 16'd1);
          write_reg(ugpb_pkg::REG_COLUMNS, 16'd1);
          write_reg(ugpb_pkg::REG_ROWS, 16'd1);
        end
        3: begin
          write_reg(ugpb_pkg::REG_ORIGIN_X, 16'h7fff);
          write_reg(ugpb_pkg::REG_ORIGIN_Y, 16'h8000);
          write_reg(ugpb_pkg::REG_CELL_SIZE, 16'd3);
          write_reg(ugpb_pkg::REG_COLUMNS, 16'd16);
          write_reg(ugpb_pkg::REG_ROWS, 16'd20);
        end
        default: begin
          write_reg(ugpb_pkg::REG_ORIGIN_X, $urandom_range(0, 400) - 200);
          write_reg(ugpb_pkg::REG_ORIGIN_Y, $urandom_range(0, 400) - 200);
          write_reg(ugpb_pkg::REG_CELL_SIZE, $urandom_range(1, 40));
          write_reg(ugpb_pkg::REG_COLUMNS, $urandom_range(1, 16));
          write_reg(ugpb_pkg::REG_ROWS, $urandom_range(1, 16));
        end
      endcase
      for (int n = 0; n < 26; n++) begin
        if (ph == 4 && n == 13) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_hits.size() != 0) @(posedge clk);
        end
        it = random_word(n == 0);
        send_word(it, 0, none);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d words in (%0d queries), %0d words out, six grid settings",
             items_sent, queries_sent, words_seen);
    $display("three sender and receiver idle mixes, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
